>>> src/xks_pkg.sv
`default_nettype none
package xks_pkg;

  localparam int DICT_WORDS  = 4096;
  localparam int WORD_BYTES  = 32;
  localparam int MSG_BYTES   = 1024;
  localparam int CHUNK_BYTES = 8;
  localparam int CHUNKS      = WORD_BYTES / CHUNK_BYTES;
  localparam int DICT_DEPTH  = DICT_WORDS * CHUNKS;
  localparam int DICT_AW     = $clog2(DICT_DEPTH);
  localparam int MSG_AW      = $clog2(MSG_BYTES);
  localparam int WIDX_W      = $clog2(DICT_WORDS);
  localparam int CIDX_W      = $clog2(CHUNKS);
  localparam int WL_W        = $clog2(WORD_BYTES) + 1;
  localparam int DSIZE_W     = 13;
  localparam int MLEN_W      = 11;
  localparam int SCORE_W     = 10;
  localparam int CFG_W       = 13;

  localparam logic [7:0]         MARK_CHAR = 8'h3F;
  localparam logic [7:0]         LAST_KEY  = 8'hFF;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 10'h3FF;
  localparam logic [DSIZE_W-1:0] DICT_LIMIT = DSIZE_W'(DICT_WORDS);
  localparam logic [MLEN_W-1:0]  MSG_LIMIT  = MLEN_W'(MSG_BYTES);

  localparam logic CFG_DICT_SIZE = 1'b0;
  localparam logic CFG_MSG_LEN   = 1'b1;

  typedef enum logic [1:0] {
    CMD_WR_DICT = 2'd0,
    CMD_WR_MSG  = 2'd1,
    CMD_RUN     = 2'd2,
    CMD_READ    = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    CMP_CONT = 2'd0,
    CMP_LT   = 2'd1,
    CMP_GT   = 2'd2,
    CMP_EQ   = 2'd3
  } cmp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_KEY_START,
    S_MSG_RD,
    S_MSG_USE,
    S_WORD,
    S_WORD_DONE,
    S_LK_CHECK,
    S_LK_CMP,
    S_KEY_END,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] dict_index;
    logic [1:0]  chunk_index;
    logic [63:0] chunk_data;
    logic [9:0]  msg_pos;
    logic [7:0]  msg_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  best_key;
    logic [9:0]  best_score;
    logic        found;
    logic [7:0]  read_char;
  } out_t;

  typedef struct packed {
    logic accept;
    logic rd_latch;
    logic key_start;
    logic msg_rd;
    logic append;
    logic advance;
    logic lk_start;
    logic word_done;
    logic lk_rd;
    logic lk_next;
    logic lk_lower;
    logic lk_upper;
    logic hit;
    logic key_end;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic at_end;
    logic wl_zero;
    logic too_long;
    logic letter;
    logic lk_empty;
    cmp_t cmp;
    logic chunk_last;
    logic last_key;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] plain_byte(input logic [7:0] enc, input logic [7:0] key);
    logic [7:0] c;
    c = enc ^ key;
    return (c < 8'h20 || c > 8'h7E) ? MARK_CHAR : c;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic cmp_t cmp_chunk(input logic [63:0] a, input logic [63:0] d);
    cmp_t r;
    logic done;
    r = CMP_CONT;
    done = 1'b0;
    for (int b = 0; b < CHUNK_BYTES; b++) begin
      if (!done) begin
        if (a[8*b +: 8] != d[8*b +: 8]) begin
          r = (a[8*b +: 8] < d[8*b +: 8]) ? CMP_LT : CMP_GT;
          done = 1'b1;
        end else if (a[8*b +: 8] == 8'h00) begin
          r = CMP_EQ;
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/xks_ram.sv
`default_nettype none
module xks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

>>> src/xks_dp.sv
`default_nettype none
module xks_dp
  import xks_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire in_t   in_data,
  input  wire logic  out_ready,
  input  wire logic  cfg_we,
  input  wire logic  cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire ctrl_t ctl,
  output stat_t      st,
  output logic       out_valid,
  output out_t       out_data
);

  logic [DSIZE_W-1:0] dictionary_size;
  logic [MLEN_W-1:0]  message_length;
  logic [DSIZE_W-1:0] dict_n;
  logic [MLEN_W-1:0]  msg_n;

  logic [7:0]         key;
  logic [7:0]         kept_key;
  logic [SCORE_W-1:0] kept_score;
  logic [SCORE_W-1:0] score;
  logic [MLEN_W-1:0]  pos;
  logic [WL_W-1:0]    wl;
  logic               too_long;
  logic [7:0]         word_buffer [WORD_BYTES];
  logic [DSIZE_W-1:0] low;
  logic [DSIZE_W-1:0] top;
  logic [WIDX_W-1:0]  mid_q;
  logic [CIDX_W-1:0]  chunk;
  logic [MSG_AW-1:0]  rd_pos;
  logic               is_read;
  logic [7:0]         char_q;

  logic [DSIZE_W:0]   mid_sum;
  logic [WIDX_W-1:0]  mid;
  logic [7:0]         cur_char;
  logic [63:0]        word_chunk;

  logic               msg_we;
  logic [MSG_AW-1:0]  msg_addr;
  logic [7:0]         msg_rdata;
  logic               dict_we;
  logic [DICT_AW-1:0] dict_addr;
  logic [63:0]        dict_rdata;

  assign dict_n   = (dictionary_size > DICT_LIMIT) ? DICT_LIMIT : dictionary_size;
  assign msg_n    = (message_length > MSG_LIMIT) ? MSG_LIMIT : message_length;
  assign mid_sum  = {1'b0, low} + {1'b0, top} - (DSIZE_W+1)'(1);
  assign mid      = mid_sum[WIDX_W:1];
  assign cur_char = plain_byte(msg_rdata, key);

  always_comb begin
    for (int b = 0; b < CHUNK_BYTES; b++) begin
      word_chunk[8*b +: 8] = word_buffer[CHUNK_BYTES * int'(chunk) + b];
    end
  end

  assign msg_we  = ctl.accept && in_data.command == CMD_WR_MSG;
  assign dict_we = ctl.accept && in_data.command == CMD_WR_DICT;

  always_comb begin
    if (ctl.msg_rd) begin
      msg_addr = pos[MSG_AW-1:0];
    end else begin
      msg_addr = in_data.msg_pos;
    end
    if (ctl.lk_rd) begin
      dict_addr = {mid, CIDX_W'(0)};
    end else if (ctl.lk_next) begin
      dict_addr = {mid_q, chunk + CIDX_W'(1)};
    end else begin
      dict_addr = {in_data.dict_index, in_data.chunk_index};
    end
  end

  xks_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_msg_ram (
    .clk  (clk),
    .we   (msg_we),
    .addr (msg_addr),
    .wdata(in_data.msg_byte),
    .rdata(msg_rdata)
  );

  xks_ram #(.WIDTH(64), .DEPTH(DICT_DEPTH)) u_dict_ram (
    .clk  (clk),
    .we   (dict_we),
    .addr (dict_addr),
    .wdata(in_data.chunk_data),
    .rdata(dict_rdata)
  );

  always_comb begin
    st.at_end     = pos == msg_n;
    st.wl_zero    = wl == '0;
    st.too_long   = too_long;
    st.letter     = is_letter(cur_char);
    st.lk_empty   = low >= top;
    st.cmp        = cmp_chunk(word_chunk, dict_rdata);
    st.chunk_last = chunk == CIDX_W'(CHUNKS - 1);
    st.last_key   = key == LAST_KEY;
    st.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dictionary_size <= '0;
      message_length  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DICT_SIZE: dictionary_size <= cfg_data[DSIZE_W-1:0];
        CFG_MSG_LEN:   message_length  <= cfg_data[MLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_key   <= '0;
      kept_score <= '0;
      key        <= '0;
      score      <= '0;
      pos        <= '0;
      wl         <= '0;
      too_long   <= 1'b0;
      out_valid  <= 1'b0;
      is_read    <= 1'b0;
      for (int j = 0; j < WORD_BYTES; j++) begin
        word_buffer[j] <= 8'h00;
      end
    end else begin
      if (ctl.accept) begin
        is_read <= in_data.command == CMD_READ;
        rd_pos  <= in_data.msg_pos;
        if (in_data.command == CMD_RUN) begin
          kept_key   <= '0;
          kept_score <= '0;
          key        <= '0;
        end
      end
      if (ctl.key_start || ctl.word_done) begin
        wl       <= '0;
        too_long <= 1'b0;
        for (int j = 0; j < WORD_BYTES; j++) begin
          word_buffer[j] <= 8'h00;
        end
      end
      if (ctl.key_start) begin
        pos   <= '0;
        score <= '0;
      end
      if (ctl.append) begin
        if (wl < WL_W'(WORD_BYTES)) begin
          word_buffer[wl[WL_W-2:0]] <= cur_char;
          wl <= wl + WL_W'(1);
        end else begin
          too_long <= 1'b1;
        end
      end
      if (ctl.append || ctl.advance) begin
        pos <= pos + MLEN_W'(1);
      end
      if (ctl.hit && score != SCORE_MAX) begin
        score <= score + SCORE_W'(1);
      end
      if (ctl.key_end) begin
        if (score > kept_score) begin
          kept_score <= score;
          kept_key   <= key;
        end
        key <= key + 8'd1;
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lk_start) begin
      low <= '0;
      top <= dict_n;
    end
    if (ctl.lk_lower) begin
      top <= {1'b0, mid_q};
    end
    if (ctl.lk_upper) begin
      low <= {1'b0, mid_q} + DSIZE_W'(1);
    end
    if (ctl.lk_rd) begin
      mid_q <= mid;
      chunk <= '0;
    end
    if (ctl.lk_next) begin
      chunk <= chunk + CIDX_W'(1);
    end
    if (ctl.rd_latch) begin
      if (kept_score != '0 && {1'b0, rd_pos} < msg_n) begin
        char_q <= plain_byte(msg_rdata, kept_key);
      end else begin
        char_q <= 8'h00;
      end
    end
    if (ctl.load_out) begin
      out_data.best_key   <= kept_key;
      out_data.best_score <= kept_score;
      out_data.found      <= kept_score != '0;
      out_data.read_char  <= is_read ? char_q : 8'h00;
    end
  end

endmodule
`default_nettype wire

>>> src/xks_ctrl.sv
`default_nettype none
module xks_ctrl
  import xks_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] command,
  input  wire stat_t      st,
  output logic            in_ready,
  output ctrl_t           ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_RUN:  state_next = S_KEY_START;
            CMD_READ: state_next = S_RD_WAIT;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT:   state_next = S_FINISH;
      S_KEY_START: state_next = S_MSG_RD;
      S_MSG_RD: begin
        if (!st.at_end) begin
          state_next = S_MSG_USE;
        end else if (!st.wl_zero) begin
          state_next = S_WORD;
        end else begin
          state_next = S_KEY_END;
        end
      end
      S_MSG_USE: begin
        if (!st.letter && !st.wl_zero) begin
          state_next = S_WORD;
        end else begin
          state_next = S_MSG_RD;
        end
      end
      S_WORD: state_next = st.too_long ? S_WORD_DONE : S_LK_CHECK;
      S_WORD_DONE: state_next = st.at_end ? S_KEY_END : S_MSG_RD;
      S_LK_CHECK: state_next = st.lk_empty ? S_WORD_DONE : S_LK_CMP;
      S_LK_CMP: begin
        case (st.cmp)
          CMP_LT:  state_next = S_LK_CHECK;
          CMP_GT:  state_next = S_LK_CHECK;
          CMP_EQ:  state_next = S_WORD_DONE;
          default: state_next = st.chunk_last ? S_WORD_DONE : S_LK_CMP;
        endcase
      end
      S_KEY_END: state_next = st.last_key ? S_FINISH : S_KEY_START;
      S_FINISH:  state_next = st.out_free ? S_IDLE : S_FINISH;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready   = !rst;
        ctl.accept = in_valid && !rst;
      end
      S_RD_WAIT:   ctl.rd_latch  = 1'b1;
      S_KEY_START: ctl.key_start = 1'b1;
      S_MSG_RD:    ctl.msg_rd    = !st.at_end;
      S_MSG_USE: begin
        ctl.append  = st.letter;
        ctl.advance = !st.letter && st.wl_zero;
      end
      S_WORD:      ctl.lk_start = !st.too_long;
      S_WORD_DONE: begin
        ctl.word_done = 1'b1;
        ctl.advance   = !st.at_end;
      end
      S_LK_CHECK:  ctl.lk_rd = !st.lk_empty;
      S_LK_CMP: begin
        case (st.cmp)
          CMP_LT:  ctl.lk_lower = 1'b1;
          CMP_GT:  ctl.lk_upper = 1'b1;
          CMP_EQ:  ctl.hit      = 1'b1;
          default: begin
            ctl.hit     = st.chunk_last;
            ctl.lk_next = !st.chunk_last;
          end
        endcase
      end
      S_KEY_END: ctl.key_end  = 1'b1;
      S_FINISH:  ctl.load_out = st.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/xor_key_search_dictionary_scorer.sv
`default_nettype none
// channel   signals                          transfer when
// in        in_valid in_ready in_data        in_valid && in_ready
// out       out_valid out_ready out_data     out_valid && out_ready
// cfg       cfg_we cfg_index cfg_data        cfg_we
//
// dictionary and message writes go to the stores when accepted; a read
// passes through a wait state and the finish state; a run reads the
// message once per key and, for each letter run, makes up to thirteen
// binary search probes on the single read port of the dictionary ram
// reset is synchronous; the stores are not cleared
// a finished result waits, input stalled, till the output register is free
module xor_key_search_dictionary_scorer
  import xks_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  ctrl_t ctl;
  stat_t st;

  xks_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .command (in_data.command),
    .st      (st),
    .in_ready(in_ready),
    .ctl     (ctl)
  );

  xks_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .out_ready(out_ready),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .st       (st),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
import xks_pkg::*;

class key_search_scoreboard;
  logic [255:0] dict_mem [DICT_WORDS];
  logic [7:0]   msg_mem [MSG_BYTES];
  int           dict_size;
  int           msg_len;
  logic [7:0]   kept_key;
  int           kept_score;
  out_t         expected_q[$];
  int           mismatches;

  function new();
    dict_size = 0;
    msg_len = 0;
    kept_key = '0;
    kept_score = 0;
    mismatches = 0;
  endfunction

  function void set_reg(logic idx, logic [CFG_W-1:0] v);
    if (idx == CFG_DICT_SIZE) begin
      dict_size = v;
    end else begin
      msg_len = v[MLEN_W-1:0];
    end
  endfunction

  function int dict_count();
    return dict_size > DICT_WORDS ? DICT_WORDS : dict_size;
  endfunction

  function int msg_count();
    return msg_len > MSG_BYTES ? MSG_BYTES : msg_len;
  endfunction

  function logic [7:0] decrypt(logic [7:0] enc, logic [7:0] k);
    logic [7:0] c;
    c = enc ^ k;
    return (c < 8'h20 || c > 8'h7E) ? MARK_CHAR : c;
  endfunction

  function bit letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // string-style bytewise compare
  function int order(logic [255:0] a, logic [255:0] d);
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (a[8*i +: 8] != d[8*i +: 8]) return (a[8*i +: 8] < d[8*i +: 8]) ? -1 : 1;
      if (a[8*i +: 8] == 8'h00) return 0;
    end
    return 0;
  endfunction

  function bit in_dict(logic [255:0] w);
    int lo;
    int hi;
    int mid;
    int c;
    lo = 0;
    hi = dict_count() - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      c = order(w, dict_mem[mid]);
      if (c == 0) return 1;
      if (c < 0) hi = mid - 1;
      else lo = mid + 1;
    end
    return 0;
  endfunction

  function int key_score(logic [7:0] k);
    int n;
    int hits;
    int wl;
    bit too_long;
    logic [255:0] wbuf;
    logic [7:0] c;
    n = msg_count();
    hits = 0;
    wl = 0;
    too_long = 0;
    wbuf = '0;
    for (int i = 0; i <= n; i++) begin
      c = (i < n) ? decrypt(msg_mem[i], k) : 8'h00;
      if (i < n && letter(c)) begin
        if (wl < WORD_BYTES) begin
          wbuf[8*wl +: 8] = c;
          wl++;
        end else begin
          too_long = 1;
        end
      end else if (wl > 0) begin
        if (!too_long && in_dict(wbuf) && hits < SCORE_MAX) hits++;
        wbuf = '0;
        wl = 0;
        too_long = 0;
      end
    end
    return hits;
  endfunction

  function void note(in_t it);
    out_t e;
    int s;
    case (command_t'(it.command))
      CMD_WR_DICT: dict_mem[it.dict_index][64*it.chunk_index +: 64] = it.chunk_data;
      CMD_WR_MSG: msg_mem[it.msg_pos] = it.msg_byte;
      CMD_RUN: begin
        kept_key = '0;
        kept_score = 0;
        for (int k = 0; k < 256; k++) begin
          s = key_score(k[7:0]);
          if (s > kept_score) begin
            kept_score = s;
            kept_key = k[7:0];
          end
        end
      end
      default: ;
    endcase
    if (it.command == CMD_RUN || it.command == CMD_READ) begin
      e.best_key = kept_key;
      e.best_score = kept_score[SCORE_W-1:0];
      e.found = kept_score > 0;
      e.read_char = (it.command == CMD_READ && kept_score > 0 && it.msg_pos < msg_count())
                    ? decrypt(msg_mem[it.msg_pos], kept_key) : 8'h00;
      expected_q.push_back(e);
    end
  endfunction

  function void check(out_t got);
    out_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result key %0d score %0d found %0d char %h",
                                     got.best_key, got.best_score, got.found, got.read_char);
      return;
    end
    e = expected_q.pop_front();
    if (got.best_key !== e.best_key || got.best_score !== e.best_score ||
        got.found !== e.found || got.read_char !== e.read_char) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp key %0d score %0d found %0d char %h, got %0d %0d %0d %h",
                 e.best_key, e.best_score, e.found, e.read_char,
                 got.best_key, got.best_score, got.found, got.read_char);
    end
  endfunction
endclass

module tb;
  localparam int LIMIT = 20000000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic [255:0] lexicon[$];
  logic [7:0] plain[$];
  key_search_scoreboard sb = new();

  xor_key_search_dictionary_scorer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stall, check each transfer
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check(out_data);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(in_t it);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note(it);
  endtask

  function automatic in_t mk(command_t c);
    in_t it;
    it.command = c;
    it.dict_index = WIDX_W'($urandom);
    it.chunk_index = CIDX_W'($urandom);
    it.chunk_data = {$urandom, $urandom};
    it.msg_pos = MSG_AW'($urandom);
    it.msg_byte = 8'($urandom);
    return it;
  endfunction

  task automatic wr_msg(int pos, logic [7:0] b);
    in_t it;
    it = mk(CMD_WR_MSG);
    it.msg_pos = MSG_AW'(pos);
    it.msg_byte = b;
    send(it);
  endtask

  task automatic wr_word(int slot, logic [255:0] w);
    in_t it;
    for (int c = 0; c < CHUNKS; c++) begin
      it = mk(CMD_WR_DICT);
      it.dict_index = WIDX_W'(slot);
      it.chunk_index = CIDX_W'(c);
      it.chunk_data = w[64*c +: 64];
      send(it);
    end
  endtask

  task automatic run_search();
    send(mk(CMD_RUN));
  endtask

  task automatic rd(int pos);
    in_t it;
    it = mk(CMD_READ);
    it.msg_pos = MSG_AW'(pos);
    send(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(int dsize, int mlen);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DICT_SIZE;
    cfg_data <= CFG_W'(dsize);
    @(posedge clk);
    sb.set_reg(CFG_DICT_SIZE, CFG_W'(dsize));
    cfg_index <= CFG_MSG_LEN;
    cfg_data <= CFG_W'(mlen);
    @(posedge clk);
    sb.set_reg(CFG_MSG_LEN, CFG_W'(mlen));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [255:0] tri_word(int i);
    logic [255:0] w;
    w = '0;
    w[7:0] = 8'(8'h61 + i / 676);
    w[15:8] = 8'(8'h61 + (i / 26) % 26);
    w[23:16] = 8'(8'h61 + i % 26);
    return w;
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(3) == 0) ? 8'(8'h41 + $urandom_range(25))
                                    : 8'(8'h61 + $urandom_range(25));
  endfunction

  task automatic load_lexicon(int n);
    logic [255:0] w;
    int j;
    lexicon.delete();
    for (int i = 0; i < n; i++) begin
      w = '0;
      for (int b = 0; b < $urandom_range(1, 5); b++) w[8*b +: 8] = rand_letter();
      j = 0;
      while (j < lexicon.size() && sb.order(lexicon[j], w) < 0) j++;
      lexicon.insert(j, w);
    end
    foreach (lexicon[i]) wr_word(i, lexicon[i]);
  endtask

  task automatic compose(int len);
    int r;
    int n;
    logic [255:0] w;
    plain.delete();
    while (plain.size() < len) begin
      r = $urandom_range(99);
      if (r < 70 && lexicon.size() > 0) begin
        w = lexicon[$urandom_range(lexicon.size() - 1)];
        for (int b = 0; b < WORD_BYTES && w[8*b +: 8] != 0; b++) plain.push_back(w[8*b +: 8]);
      end else if (r < 80) begin
        n = $urandom_range(1, 6);
        repeat (n) plain.push_back(rand_letter());
      end else if (r < 85) begin
        n = $urandom_range(33, 40);
        repeat (n) plain.push_back(8'h71);
      end else begin
        plain.push_back(8'($urandom));
      end
      case ($urandom_range(4))
        0, 1: plain.push_back(8'h20);
        2: plain.push_back(8'h2E);
        3: plain.push_back(8'h0A);
        default: plain.push_back(8'($urandom));
      endcase
    end
    while (plain.size() > len) void'(plain.pop_back());
  endtask

  task automatic write_text(logic [7:0] k);
    foreach (plain[i]) wr_msg(i, plain[i] ^ k);
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) plain.push_back(s[i]);
  endtask

  initial begin
    logic [255:0] w;
    int n;
    int len;
    logic [7:0] k;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // whole stores written once, sorted three-letter words
    for (int i = 0; i < DICT_WORDS; i++) wr_word(i, tri_word(i));
    for (int i = 0; i < MSG_BYTES; i++) wr_msg(i, 8'($urandom));
    rd(3);

    // oversized dictionary size, full dictionary
    settle();
    configure(8191, 24);
    lexicon.delete();
    repeat (6) lexicon.push_back(tri_word($urandom_range(DICT_WORDS - 1)));
    compose(24);
    write_text(8'hFF);
    run_search();
    rd(0);
    rd(23);
    rd(24);
    rd(1023);

    // empty dictionary, oversized message length
    settle();
    configure(0, 2047);
    run_search();
    rd(5);
    rd(1023);

    // full slot and long words
    settle();
    configure(3, 90);
    w = '0;
    for (int b = 0; b < WORD_BYTES; b++) w[8*b +: 8] = 8'h7A;
    wr_word(0, {232'h0, "goD"});
    wr_word(1, {232'h0, "tac"});
    wr_word(2, w);
    plain.delete();
    push_str("Dog cat ");
    repeat (32) plain.push_back(8'h7A);
    plain.push_back(8'h20);
    repeat (33) plain.push_back(8'h7A);
    push_str(". cat!");
    write_text(8'h00);
    run_search();
    rd(0);
    wr_msg(0, 8'h00);
    rd(0);
    rd(89);
    settle();
    configure(3, 2);
    rd(1);
    rd(4);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 67; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 67; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      for (int s = 0; s < 2; s++) begin
        n = $urandom_range(1, 12);
        len = $urandom_range(4, 24);
        settle();
        configure(n, len);
        load_lexicon(n);
        k = 8'($urandom);
        if ($urandom_range(4) == 0) begin
          plain.delete();
          repeat (len) plain.push_back(8'($urandom));
        end else begin
          compose(len);
        end
        write_text(k);
        if ($urandom_range(1)) begin
          wr_word($urandom_range(n, DICT_WORDS - 1) ,
                  {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end
        run_search();
        repeat (6) rd($urandom_range(len + 3));
        repeat (2) wr_msg($urandom_range(len - 1), 8'($urandom));
        repeat (4) rd($urandom_range(len - 1));
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

>>> files.f
src/xks_pkg.sv
src/xks_ram.sv
src/xks_dp.sv
src/xks_ctrl.sv
src/xor_key_search_dictionary_scorer.sv
dv/tb.sv
